// File: hdl/imab_pkg.sv
// Shared types and constants for the interarrival moving-average binner.
`timescale 1ns / 1ps

package imab_pkg;

    // Field widths
    localparam int TIME_W    = 62;
    localparam int DELTA_W   = 32;
    localparam int IV_W      = 48;
    localparam int BIN_W     = 4;
    localparam int BCNT_W    = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 48;

    // Shared divider widths
    localparam int DIV_W     = 48;
    localparam int STEP_W    = 6;

    // Divider step counts
    localparam logic [STEP_W-1:0] STEPS_FULL = 6'd48;
    localparam logic [STEP_W-1:0] STEPS_BIN  = 6'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_LOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_HIGH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT = 2'd2;

    // Configuration reset values
    localparam logic [IV_W-1:0]   BIN_LOW_RST   = 48'd0;
    localparam logic [IV_W-1:0]   BIN_HIGH_RST  = 48'd2765653;
    localparam logic [BCNT_W-1:0] BIN_COUNT_RST = 5'd10;
    localparam logic [BCNT_W-1:0] BIN_COUNT_MAX = 5'd16;

    localparam logic [IV_W-1:0]   IV_MAX = {IV_W{1'b1}};

    // Divider request: remainder seed, dividend bits still to shift in
    // (left aligned), divisor and number of quotient bits to produce
    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  rem;
        logic [DIV_W-1:0]  low;
        logic [DIV_W-1:0]  dvs;
        logic [STEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } t_div_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_IV_START,
        ST_IV_WAIT,
        ST_SUB,
        ST_ADD,
        ST_MEAN_START,
        ST_MEAN_WAIT,
        ST_BIN_SETUP,
        ST_BIN_WAIT,
        ST_FINISH
    } t_state;

endpackage

// File: hdl/imab_in_if.sv
// Acknowledgment event channel.
`timescale 1ns / 1ps

interface imab_in_if import imab_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [TIME_W-1:0]  event_time;
    logic [DELTA_W-1:0] seq_delta;

    modport source (output valid, output event_time, output seq_delta, input ready);
    modport sink   (input valid, input event_time, input seq_delta, output ready);
endinterface

// File: hdl/imab_out_if.sv
// Result channel: windowed mean, bin and error flag.
`timescale 1ns / 1ps

interface imab_out_if import imab_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IV_W-1:0]  average_interval;
    logic [BIN_W-1:0] bin_index;
    logic             bad_delta;

    modport source (output valid, output average_interval, output bin_index,
                    output bad_delta, input ready);
    modport sink   (input valid, input average_interval, input bin_index,
                    input bad_delta, output ready);
endinterface

// File: hdl/imab_div.sv
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module imab_div import imab_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_low;
    logic [DIV_W-1:0]  r_dvs;
    logic [STEP_W-1:0] r_left;

    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    trial_sub;
    logic              fits;

    // Shift in the next dividend bit and try the subtract
    always_comb begin
        trial     = {r_rem, r_low[DIV_W-1]};
        trial_sub = trial - {1'b0, r_dvs};
        fits      = (trial >= {1'b0, r_dvs});
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_left <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_left <= i_req.steps;
            end else if (r_busy) begin
                r_left <= r_left - 1'b1;
                if (r_left == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient bits fill the low end of the shift register
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem;
            r_low <= i_req.low;
            r_dvs <= i_req.dvs;
        end else if (r_busy) begin
            r_rem <= fits ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
            r_low <= {r_low[DIV_W-2:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_low;

endmodule

// File: hdl/interarrival_moving_average_binner_unit.sv
// Top level: interarrival interval, ring-buffer moving average and binning.
//
//   channel   dir   handshake        payload
//   i_ack     in    valid / ready    event_time[61:0], seq_delta[31:0]
//   o_res     out   valid / ready    average_interval[47:0], bin_index[3:0], bad_delta
//   i_cfg_*   in    write enable     index 0 bin_low, 1 bin_high, 2 bin_count
//
// One item at a time. The shared one-bit-per-cycle divider sets the pace:
// 48 steps for the interval, 48 for the mean, 4 for the bin; a zero
// advance skips the interval division.
// Synchronous reset clears control state; the ring needs no clearing pass,
// since an old slot value is used only once written. A finished result waits in
// the output register while the next item is taken; a stalled output holds
// the block in its last state until that register frees.
`timescale 1ns / 1ps

module interarrival_moving_average_binner_unit import imab_pkg::*; #(
    parameter int WINDOW_DEPTH = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    imab_in_if.sink              i_ack,
    imab_out_if.source           o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int POS_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = IV_W + $clog2(WINDOW_DEPTH);

    // Configuration
    logic [IV_W-1:0]   r_bin_low;
    logic [IV_W-1:0]   r_bin_high;
    logic [BCNT_W-1:0] r_bin_count;

    // Window state
    logic [TIME_W-1:0] r_prev;
    logic [POS_W-1:0]  r_pos;
    logic [CNT_W-1:0]  r_cnt;
    logic [SUM_W-1:0]  r_sum;
    logic [IV_W-1:0]   ring [WINDOW_DEPTH];
    logic [IV_W-1:0]   r_old;

    // Item working registers
    t_state             r_state;
    t_state             n_state;
    logic [TIME_W-1:0]  r_time;
    logic [DELTA_W-1:0] r_delta;
    logic [IV_W-1:0]    r_iv;
    logic [IV_W-1:0]    r_mean;
    logic [BIN_W-1:0]   r_bin;
    logic               r_bad;

    // Output register
    logic               r_out_valid;
    logic [IV_W-1:0]    r_out_avg;
    logic [BIN_W-1:0]   r_out_bin;
    logic               r_out_bad;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic               in_acc;
    logic               out_free;
    logic               ring_full;
    logic [TIME_W-1:0]  time_diff;
    logic               time_fwd;
    logic               iv_sat;
    logic [BCNT_W-1:0]  bin_n;
    logic [IV_W-1:0]    bin_span;
    logic [IV_W+BCNT_W-1:0] bin_num;
    logic               bin_top;
    logic               bin_out;

    assign in_acc    = i_ack.valid && i_ack.ready;
    assign out_free  = !r_out_valid || o_res.ready;
    assign ring_full = (r_cnt == CNT_W'(WINDOW_DEPTH));

    // Interval terms
    assign time_fwd  = (r_time > r_prev);
    assign time_diff = r_time - r_prev;
    assign iv_sat    = ({{(DELTA_W-(TIME_W-IV_W)){1'b0}}, time_diff[TIME_W-1:IV_W]} >= r_delta);

    // Bin terms; bin count folds into 1..16
    always_comb begin
        if (r_bin_count == '0) begin
            bin_n = 5'd1;
        end else if (r_bin_count > BIN_COUNT_MAX) begin
            bin_n = BIN_COUNT_MAX;
        end else begin
            bin_n = r_bin_count;
        end
    end

    assign bin_span = r_bin_high - r_bin_low;
    assign bin_num  = (IV_W+BCNT_W)'(r_mean - r_bin_low) * (IV_W+BCNT_W)'(bin_n);
    assign bin_top  = (r_mean == r_bin_high);
    assign bin_out  = (r_bin_high <= r_bin_low) || (r_mean < r_bin_low)
                      || (r_mean > r_bin_high);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_low   <= BIN_LOW_RST;
            r_bin_high  <= BIN_HIGH_RST;
            r_bin_count <= BIN_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BIN_LOW:   r_bin_low   <= i_cfg_data[IV_W-1:0];
                CFG_BIN_HIGH:  r_bin_high  <= i_cfg_data[IV_W-1:0];
                CFG_BIN_COUNT: r_bin_count <= i_cfg_data[BCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Next state and divider requests
    always_comb begin
        n_state       = r_state;
        div_req.start = 1'b0;
        div_req.rem   = '0;
        div_req.low   = '0;
        div_req.dvs   = '0;
        div_req.steps = STEPS_FULL;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (i_ack.seq_delta == '0) ? ST_MEAN_START : ST_IV_START;
                end
            end
            ST_IV_START: begin
                if (!time_fwd || iv_sat) begin
                    n_state = ST_SUB;
                end else begin
                    div_req.start = 1'b1;
                    div_req.rem   = DIV_W'(time_diff[TIME_W-1:IV_W]);
                    div_req.low   = time_diff[IV_W-1:0];
                    div_req.dvs   = DIV_W'(r_delta);
                    n_state       = ST_IV_WAIT;
                end
            end
            ST_IV_WAIT: begin
                if (div_rsp.done) begin
                    n_state = ST_SUB;
                end
            end
            ST_SUB: n_state = ST_ADD;
            ST_ADD: n_state = ST_MEAN_START;
            ST_MEAN_START: begin
                if (r_cnt == '0) begin
                    n_state = ST_BIN_SETUP;
                end else begin
                    div_req.start = 1'b1;
                    div_req.rem   = DIV_W'(r_sum >> IV_W);
                    div_req.low   = r_sum[IV_W-1:0];
                    div_req.dvs   = DIV_W'(r_cnt);
                    n_state       = ST_MEAN_WAIT;
                end
            end
            ST_MEAN_WAIT: begin
                if (div_rsp.done) begin
                    n_state = ST_BIN_SETUP;
                end
            end
            ST_BIN_SETUP: begin
                if (bin_top || bin_out) begin
                    n_state = ST_FINISH;
                end else begin
                    div_req.start = 1'b1;
                    div_req.rem   = DIV_W'(bin_num >> BIN_W);
                    div_req.low   = {bin_num[BIN_W-1:0], {(DIV_W-BIN_W){1'b0}}};
                    div_req.dvs   = bin_span;
                    div_req.steps = STEPS_BIN;
                    n_state       = ST_BIN_WAIT;
                end
            end
            ST_BIN_WAIT: begin
                if (div_rsp.done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State register and window control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_prev  <= '0;
            r_pos   <= '0;
            r_cnt   <= '0;
            r_sum   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SUB) begin
                r_prev <= r_time;
                if (ring_full) begin
                    r_sum <= r_sum - SUM_W'(r_old);
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
                if (r_pos == POS_W'(WINDOW_DEPTH - 1)) begin
                    r_pos <= '0;
                end else begin
                    r_pos <= r_pos + 1'b1;
                end
            end else if (r_state == ST_ADD) begin
                r_sum <= r_sum + SUM_W'(r_iv);
            end
        end
    end

    // Ring memory: read the outgoing slot on accept, write the new interval back
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_old <= ring[r_pos];
        end
        if (r_state == ST_SUB) begin
            ring[r_pos] <= r_iv;
        end
    end

    // Item payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_time <= i_ack.event_time;
            r_delta <= i_ack.seq_delta;
            r_bad  <= (i_ack.seq_delta == '0);
        end
        if (r_state == ST_IV_START) begin
            r_iv <= !time_fwd ? '0 : IV_MAX;
        end else if (r_state == ST_IV_WAIT && div_rsp.done) begin
            r_iv <= div_rsp.quot;
        end
        if (r_state == ST_MEAN_START) begin
            r_mean <= '0;
        end else if (r_state == ST_MEAN_WAIT && div_rsp.done) begin
            r_mean <= div_rsp.quot;
        end
        if (r_state == ST_BIN_SETUP) begin
            r_bin <= bin_top ? BIN_W'(bin_n - 5'd1) : '0;
        end else if (r_state == ST_BIN_WAIT && div_rsp.done) begin
            r_bin <= ({1'b0, div_rsp.quot[BIN_W-1:0]} >= bin_n) ? '0
                     : div_rsp.quot[BIN_W-1:0];
        end
    end

    // Output register: load on finish, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_FINISH && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FINISH && out_free) begin
            r_out_avg <= r_mean;
            r_out_bin <= r_bin;
            r_out_bad <= r_bad;
        end
    end

    imab_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign i_ack.ready            = (r_state == ST_IDLE);
    assign o_res.valid            = r_out_valid;
    assign o_res.average_interval = r_out_avg;
    assign o_res.bin_index        = r_out_bin;
    assign o_res.bad_delta        = r_out_bad;

endmodule

// File: tb/tb_interarrival_moving_average_binner_unit.sv
// Self-checking testbench for the interarrival moving-average binner.
`timescale 1ns / 1ps

module tb_interarrival_moving_average_binner_unit;
    import imab_pkg::*;

    localparam int WINDOW      = 1024;
    localparam int PHASES      = 12;
    localparam int PHASE_ACKS  = 69;
    localparam int HOLD_CYCLES = 600;
    localparam int END_SETTLE  = 150;
    localparam int CYCLE_LIMIT = 1_500_000;

    // One expected result: windowed mean, its bin and the zero-advance flag
    typedef struct packed {
        logic [IV_W-1:0]  mean;
        logic [BIN_W-1:0] bin_idx;
        logic             bad;
    } t_mean_rec;

    // One row of the directed table: a register write or an acknowledgment
    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DAT_W-1:0] data;
        logic [TIME_W-1:0]    t;
        logic [DELTA_W-1:0]   d;
        bit                   typed;
        t_mean_rec            want;
    } t_plan_row;

    logic i_clk;
    logic i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    imab_in_if  ack_if ();
    imab_out_if res_if ();

    interarrival_moving_average_binner_unit #(
        .WINDOW_DEPTH(WINDOW)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ack       (ack_if),
        .o_res       (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Window model state and register copies
    logic [TIME_W-1:0] last_time;
    logic [IV_W-1:0]   iv_ring [WINDOW];
    int unsigned       ring_wr;
    int unsigned       iv_count;
    logic [63:0]       iv_sum;
    logic [IV_W-1:0]   cfg_low;
    logic [IV_W-1:0]   cfg_high;
    logic [BCNT_W-1:0] cfg_bins;

    t_mean_rec mean_queue [$];
    t_plan_row plan [$];

    // Traffic shaping
    bit          send_quiet;
    bit          recv_quiet;
    bit          hold_req;
    int          hold_left;
    int          burst_left;
    logic [15:0] stall_pat;
    int          stall_ph;
    logic [31:0] phase_iv;

    // Bookkeeping
    int errors;
    int cycle_count;
    int n_acks;
    int n_bad;
    int n_sat;
    int n_wrap;
    int n_writes;

    always #5 i_clk = ~i_clk;

    // Mean of the intervals now in the window, zero while it is empty
    function automatic logic [IV_W-1:0] window_mean();
        if (iv_count == 0) return '0;
        return IV_W'(iv_sum / 64'(iv_count));
    endfunction

    // Uniform bin of a mean between the configured bounds
    function automatic logic [BIN_W-1:0] mean_bin(input logic [IV_W-1:0] v);
        logic [63:0] n;
        logic [63:0] span;
        logic [63:0] b;
        n = (cfg_bins == 0) ? 64'd1 : (cfg_bins > BIN_COUNT_MAX) ? 64'd16 : 64'(cfg_bins);
        if (v == cfg_high) return BIN_W'(n - 1);
        if (cfg_high <= cfg_low) return '0;
        if (v < cfg_low || v > cfg_high) return '0;
        span = 64'(cfg_high) - 64'(cfg_low);
        b = ((64'(v) - 64'(cfg_low)) * n) / span;
        if (b >= n) b = 0;
        return BIN_W'(b);
    endfunction

    // Fold one acknowledgment into the window and form its result
    function automatic t_mean_rec take_ack(input logic [TIME_W-1:0] t,
                                           input logic [DELTA_W-1:0] d);
        t_mean_rec r;
        logic [63:0] iv;
        r.bad = (d == 0);
        if (d != 0) begin
            iv = '0;
            if (t > last_time) begin
                iv = (64'(t) - 64'(last_time)) / 64'(d);
                if (iv > 64'(IV_MAX)) begin
                    iv = 64'(IV_MAX);
                    n_sat++;
                end
            end
            if (iv_count < WINDOW) begin
                iv_sum += iv;
                iv_count++;
            end else begin
                iv_sum = iv_sum - 64'(iv_ring[ring_wr]) + iv;
                n_wrap++;
            end
            iv_ring[ring_wr] = iv[IV_W-1:0];
            ring_wr = (ring_wr == WINDOW - 1) ? 0 : ring_wr + 1;
            last_time = t;
        end else begin
            n_bad++;
        end
        r.mean    = window_mean();
        r.bin_idx = mean_bin(r.mean);
        return r;
    endfunction

    // Directed table builders
    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DAT_W-1:0] data);
        t_plan_row r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        plan.push_back(r);
    endfunction

    function automatic void add_ack(input logic [TIME_W-1:0] t, input logic [DELTA_W-1:0] d);
        t_plan_row r;
        r = '{default: '0};
        r.t = t;
        r.d = d;
        plan.push_back(r);
    endfunction

    function automatic void add_known(input logic [TIME_W-1:0] t, input logic [DELTA_W-1:0] d,
                                      input logic [IV_W-1:0] mean,
                                      input logic [BIN_W-1:0] bin_idx, input logic bad);
        t_plan_row r;
        r = '{default: '0};
        r.t     = t;
        r.d     = d;
        r.typed = 1'b1;
        r.want  = '{mean: mean, bin_idx: bin_idx, bad: bad};
        plan.push_back(r);
    endfunction

    // Write one register at the next rising edge and track it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_BIN_LOW:   cfg_low  = data[IV_W-1:0];
            CFG_BIN_HIGH:  cfg_high = data[IV_W-1:0];
            CFG_BIN_COUNT: cfg_bins = data[BCNT_W-1:0];
            default: ;
        endcase
        n_writes++;
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic drain(input int settle);
        @(negedge i_clk);
        ack_if.valid <= 1'b0;
        while (mean_queue.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Offer one item in bursts with random gaps; predict it once accepted
    task automatic push_event(input logic [TIME_W-1:0] t, input logic [DELTA_W-1:0] d,
                              input bit typed, input t_mean_rec want);
        int gap;
        t_mean_rec got;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = (send_quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 160);
            if (gap > 0) begin
                @(negedge i_clk);
                ack_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        ack_if.valid      <= 1'b1;
        ack_if.event_time <= t;
        ack_if.seq_delta  <= d;
        do @(posedge i_clk); while (!ack_if.ready);
        got = take_ack(t, d);
        mean_queue.push_back(typed ? want : got);
        n_acks++;
    endtask

    // Random acknowledgment: mostly steady arrivals around the phase interval
    task automatic make_ack(output logic [TIME_W-1:0] t, output logic [DELTA_W-1:0] d);
        int unsigned pick;
        logic [63:0] r64;
        logic [63:0] step;
        pick = $urandom_range(0, 199);
        r64  = {$urandom, $urandom};
        d    = $urandom_range(1, 16);
        step = 64'(phase_iv) * d / 2 + 64'($urandom_range(0, phase_iv * d));
        if (pick < 8) begin
            // zero advance at any time
            d = '0;
            t = r64[TIME_W-1:0];
        end else if (pick < 14) begin
            // anywhere in time, any advance
            t = r64[TIME_W-1:0];
            d = $urandom;
        end else if (pick < 20) begin
            // time standing still or going backwards
            t = last_time - TIME_W'($urandom_range(0, 1000));
        end else if (pick < 22) begin
            // huge jump that saturates the interval
            d = 32'd1;
            t = last_time + (r64[TIME_W-1:0] | (TIME_W'(1) << 55));
        end else if (pick < 30) begin
            // large advance shrinks the interval toward zero
            d = ($urandom_range(0, 3) == 0) ? '1 : ($urandom | 32'd1);
            t = last_time + TIME_W'(64'($urandom) << $urandom_range(0, 24));
        end else begin
            t = last_time + TIME_W'(step);
        end
    endtask

    // Bounds straddling the current mean so that the bins spread
    task automatic bounds_near_mean(input logic [BCNT_W-1:0] count);
        logic [63:0] m;
        logic [63:0] w;
        logic [63:0] hi;
        m  = 64'(window_mean());
        w  = m / $urandom_range(2, 16) + $urandom_range(1, 100);
        hi = m + w;
        if (hi > 64'(IV_MAX)) hi = 64'(IV_MAX);
        write_reg(CFG_BIN_LOW, CFG_DAT_W'((m > w) ? m - w : 64'd0));
        write_reg(CFG_BIN_HIGH, CFG_DAT_W'(hi));
        write_reg(CFG_BIN_COUNT, CFG_DAT_W'(count));
    endtask

    // Set up one random phase: registers, traffic shape, interval scale
    task automatic setup_phase(input int ph);
        logic [63:0] a;
        logic [63:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        send_quiet = 1'b0;
        recv_quiet = 1'b0;
        phase_iv   = $urandom_range(10, 3_000_000);
        case (ph)
            0:  bounds_near_mean(5'd10);
            1:  begin
                bounds_near_mean(5'd16);
                send_quiet = 1'b1;
            end
            2:  bounds_near_mean(5'd1);
            3:  begin
                bounds_near_mean(5'd0);
                send_quiet = 1'b1;
                recv_quiet = 1'b1;
            end
            4:  bounds_near_mean(BCNT_W'($urandom_range(17, 31)));
            5:  begin
                write_reg(CFG_BIN_LOW, '0);
                write_reg(CFG_BIN_HIGH, CFG_DAT_W'(IV_MAX));
                write_reg(CFG_BIN_COUNT, CFG_DAT_W'(BIN_COUNT_MAX));
            end
            6:  begin
                // inverted range
                write_reg(CFG_BIN_LOW, CFG_DAT_W'(a[IV_W-1:0] | (IV_W'(1) << 47)));
                write_reg(CFG_BIN_HIGH, CFG_DAT_W'(b[IV_W-2:0]));
            end
            7:  begin
                write_reg(CFG_BIN_LOW, a[CFG_DAT_W-1:0]);
                write_reg(CFG_BIN_HIGH, b[CFG_DAT_W-1:0]);
                write_reg(CFG_BIN_COUNT, CFG_DAT_W'($urandom_range(0, 31)));
                send_quiet = 1'b1;
            end
            10: begin
                bounds_near_mean(BCNT_W'($urandom_range(1, 16)));
                send_quiet = 1'b1;
                recv_quiet = 1'b1;
            end
            default: bounds_near_mean(BCNT_W'($urandom_range(1, 16)));
        endcase
    endtask

    // Result checker: compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_mean_rec want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (mean_queue.size() == 0) begin
                errors++;
                if (errors <= 200)
                    $display("%0t: result with nothing expected: mean %0d bin %0d bad %0b",
                             $time, res_if.average_interval, res_if.bin_index,
                             res_if.bad_delta);
            end else begin
                want = mean_queue.pop_front();
                if (res_if.average_interval !== want.mean) begin
                    errors++;
                    if (errors <= 200)
                        $display("%0t: average_interval expected %0d got %0d",
                                 $time, want.mean, res_if.average_interval);
                end
                if (res_if.bin_index !== want.bin_idx) begin
                    errors++;
                    if (errors <= 200)
                        $display("%0t: bin_index expected %0d got %0d",
                                 $time, want.bin_idx, res_if.bin_index);
                end
                if (res_if.bad_delta !== want.bad) begin
                    errors++;
                    if (errors <= 200)
                        $display("%0t: bad_delta expected %0b got %0b",
                                 $time, want.bad, res_if.bad_delta);
                end
            end
        end
    end

    // Receiver: long hold on request, always ready when quiet, otherwise a reloaded stall pattern
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            res_if.ready <= 1'b0;
            hold_left--;
        end else if (recv_quiet) begin
            res_if.ready <= 1'b1;
        end else begin
            if (stall_ph == 0)
                stall_pat = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                        : 16'($urandom | $urandom);
            res_if.ready <= stall_pat[stall_ph];
            stall_ph = (stall_ph + 1) % 16;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("interarrival_moving_average_binner_unit regression: fail");
            $finish;
        end
    end

    initial begin
        logic [TIME_W-1:0]  t;
        logic [DELTA_W-1:0] d;

        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = '0;
        i_cfg_data        = '0;
        ack_if.valid      = 1'b0;
        ack_if.event_time = '0;
        ack_if.seq_delta  = '0;
        res_if.ready      = 1'b0;
        send_quiet        = 1'b0;
        recv_quiet        = 1'b0;
        hold_req          = 1'b0;
        hold_left         = 0;
        burst_left        = 0;
        stall_pat         = '0;
        stall_ph          = 0;
        phase_iv          = 32'd1000;
        errors            = 0;
        cycle_count       = 0;
        n_acks            = 0;
        n_bad             = 0;
        n_sat             = 0;
        n_wrap            = 0;
        n_writes          = 0;

        last_time = '0;
        ring_wr   = 0;
        iv_count  = 0;
        iv_sum    = '0;
        cfg_low   = BIN_LOW_RST;
        cfg_high  = BIN_HIGH_RST;
        cfg_bins  = BIN_COUNT_RST;

        // Directed table, starting from the reset registers
        add_known(62'd100, 32'd0, 48'd0, 4'd0, 1'b1);     // zero advance, empty window
        add_known(62'd1000, 32'd1, 48'd1000, 4'd0, 1'b0);
        add_known(62'd1000, 32'd1, 48'd500, 4'd0, 1'b0);  // time standing still
        add_known(62'd500, 32'd3, 48'd333, 4'd0, 1'b0);   // time going backwards
        add_cfg(CFG_BIN_HIGH, 48'd333);
        add_known(62'd7, 32'd0, 48'd333, 4'd9, 1'b1);     // mean on the upper bound
        add_cfg(CFG_BIN_COUNT, 48'd16);
        add_known(62'd7, 32'd0, 48'd333, 4'd15, 1'b1);
        add_cfg(CFG_BIN_COUNT, 48'd0);
        add_known(62'd7, 32'd0, 48'd333, 4'd0, 1'b1);     // zero bins act as one
        add_cfg(CFG_BIN_COUNT, 48'd31);
        add_known(62'd7, 32'd0, 48'd333, 4'd15, 1'b1);    // too many bins clip to 16
        add_cfg(CFG_BIN_HIGH, 48'd334);
        add_known(62'd7, 32'd0, 48'd333, 4'd15, 1'b1);
        add_cfg(CFG_BIN_COUNT, 48'd4);
        add_known(62'd7, 32'd0, 48'd333, 4'd3, 1'b1);
        add_cfg(CFG_BIN_LOW, 48'd334);
        add_cfg(CFG_BIN_HIGH, 48'd1000);
        add_known(62'd7, 32'd0, 48'd333, 4'd0, 1'b1);     // mean below range
        add_cfg(CFG_BIN_LOW, 48'd1000);
        add_cfg(CFG_BIN_HIGH, 48'd10);
        add_known(62'd7, 32'd0, 48'd333, 4'd0, 1'b1);     // inverted range
        add_cfg(CFG_BIN_HIGH, 48'd333);
        add_known(62'd7, 32'd0, 48'd333, 4'd3, 1'b1);     // inverted, mean on upper bound
        add_cfg(CFG_BIN_LOW, 48'd0);
        add_cfg(CFG_BIN_HIGH, 48'd332);
        add_known(62'd7, 32'd0, 48'd333, 4'd0, 1'b1);     // mean above range
        add_cfg(CFG_BIN_HIGH, CFG_DAT_W'(BIN_HIGH_RST));
        add_ack(62'h3_0000_01F4, 32'hFFFF_FFFF);
        add_ack('1, 32'd1);                               // saturated interval
        add_ack(62'd0, 32'hFFFF_FFFF);
        add_ack(62'h2AAA_AAAA_AAAA_AAAA, 32'h5555_5555);
        add_ack(62'h1555_5555_5555_5555, 32'hAAAA_AAAA);
        add_ack(62'h3555_5555_5555_5555, 32'h8000_0000);
        add_cfg(CFG_BIN_HIGH, CFG_DAT_W'(IV_MAX));
        add_cfg(CFG_BIN_COUNT, 48'd16);
        add_ack(62'h3FFF_FFFF_FFFF_FFF0, 32'd0);
        add_cfg(CFG_BIN_LOW, CFG_DAT_W'(IV_MAX));
        add_ack(62'd0, 32'd0);

        // Hold reset, then release it at a falling edge
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                drain(4);
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                push_event(plan[i].t, plan[i].d, plan[i].typed, plan[i].want);
            end
        end

        // Random phases; each starts idle and rewrites the bin bounds
        for (int ph = 0; ph < PHASES; ph++) begin
            drain(4);
            setup_phase(ph);
            for (int k = 0; k < PHASE_ACKS; k++) begin
                if ((ph == 1 || ph == 7) && k == 40) hold_req = 1'b1;
                make_ack(t, d);
                push_event(t, d, 1'b0, '0);
            end
        end

        drain(END_SETTLE);
        $display("Covered %0d events: %0d zero advances, %0d saturated intervals, %0d past wrap",
                 n_acks, n_bad, n_sat, n_wrap);
        $display("%0d register writes over %0d random phases, %0d mismatches",
                 n_writes, PHASES, errors);
        if (errors == 0)
            $display("interarrival_moving_average_binner_unit regression: pass");
        else
            $display("interarrival_moving_average_binner_unit regression: fail");
        $finish;
    end

endmodule

// File: interarrival_moving_average_binner_unit.f
hdl/imab_pkg.sv
hdl/imab_in_if.sv
hdl/imab_out_if.sv
hdl/imab_div.sv
hdl/interarrival_moving_average_binner_unit.sv
tb/tb_interarrival_moving_average_binner_unit.sv
